[sv/oaht_pkg.sv]
package oaht_pkg;

	localparam int TIME_W     = 32;
	localparam int POWER_W    = 20;
	localparam int TEMP_W     = 8;
	localparam int SPAN_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SUN_ON_TEMP    = 3'd0,
		REG_SUN_OFF_TEMP   = 3'd1,
		REG_DARK_ON_TEMP   = 3'd2,
		REG_DARK_OFF_TEMP  = 3'd3,
		REG_LIGHT_POWER_MW = 3'd4,
		REG_TUMBLE_TIME_S  = 3'd5,
		REG_ORBIT_PERIOD_S = 3'd6,
		REG_HEATUP_TIME_S  = 3'd7
	} reg_idx_t;

	// Temperatures are two's complement bit patterns
	typedef struct packed {
		logic [TEMP_W-1:0]  sun_on_temp;
		logic [TEMP_W-1:0]  sun_off_temp;
		logic [TEMP_W-1:0]  dark_on_temp;
		logic [TEMP_W-1:0]  dark_off_temp;
		logic [POWER_W-1:0] light_power_mw;
		logic [SPAN_W-1:0]  tumble_time_s;
		logic [SPAN_W-1:0]  orbit_period_s;
		logic [SPAN_W-1:0]  heatup_time_s;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		sun_on_temp:    8'sd0,
		sun_off_temp:   8'sd5,
		dark_on_temp:   8'sd0,
		dark_off_temp:  8'sd5,
		light_power_mw: 20'd0,
		tumble_time_s:  16'd0,
		orbit_period_s: 16'd5400,
		heatup_time_s:  16'd0
	};

	typedef struct packed {
		logic [TIME_W-1:0]  now_s;
		logic [POWER_W-1:0] panel_power_mw;
		logic [TEMP_W-1:0]  temperature;
	} tick_t;

	typedef struct packed {
		logic              profile;
		logic              heater;
		logic [TIME_W-1:0] last_light;
		logic [TIME_W-1:0] first_light;
	} state_t;

	localparam state_t STATE_RESET = '{
		profile:     1'b0,
		heater:      1'b0,
		last_light:  '0,
		first_light: '0
	};

endpackage

[sv/oaht_if.sv]
interface oaht_tick_if;
	import oaht_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [TIME_W-1:0]        now_s;
	logic [POWER_W-1:0]       panel_power_mw;
	logic signed [TEMP_W-1:0] temperature;

	modport source(output valid, now_s, panel_power_mw, temperature, input ready);
	modport sink(input valid, now_s, panel_power_mw, temperature, output ready);
endinterface

interface oaht_result_if;
	logic valid;
	logic ready;
	logic heater_drive;
	logic sunshine_profile;

	modport source(output valid, heater_drive, sunshine_profile, input ready);
	modport sink(input valid, heater_drive, sunshine_profile, output ready);
endinterface

[sv/oaht_step.sv]
module oaht_step (
	input  oaht_pkg::cfg_t   cfg,
	input  oaht_pkg::state_t cur,
	input  oaht_pkg::tick_t  tick,
	output oaht_pkg::state_t nxt
);
	import oaht_pkg::*;

	logic              lit;
	logic [TIME_W-1:0] gap;
	logic              dark;
	logic              new_orbit;
	logic              profile_mid;
	logic [TIME_W-1:0] first_mid;
	logic              refresh;
	logic              still_dark;
	logic [SPAN_W-1:0] delay;
	logic [TIME_W-1:0] since_first;
	logic signed [TEMP_W-1:0] temp;
	logic signed [TEMP_W-1:0] on_t;
	logic signed [TEMP_W-1:0] off_t;

	always_comb begin
		lit         = tick.panel_power_mw > cfg.light_power_mw;
		gap         = tick.now_s - cur.last_light;
		dark        = gap > {{(TIME_W-SPAN_W){1'b0}}, cfg.tumble_time_s};
		new_orbit   = lit && dark;
		profile_mid = new_orbit || cur.profile;
		first_mid   = new_orbit ? tick.now_s : cur.first_light;
		// a refresh zeroes the gap, so the darkness test can only pass without one
		refresh     = lit && profile_mid;
		still_dark  = !refresh && dark;
		delay       = (cfg.heatup_time_s > cfg.orbit_period_s) ? '0
			: cfg.orbit_period_s - cfg.heatup_time_s;
		since_first = tick.now_s - first_mid;

		nxt.first_light = first_mid;
		nxt.last_light  = refresh ? tick.now_s : cur.last_light;
		nxt.profile     = still_dark ? (since_first > {{(TIME_W-SPAN_W){1'b0}}, delay})
			: profile_mid;

		temp  = $signed(tick.temperature);
		on_t  = nxt.profile ? $signed(cfg.sun_on_temp) : $signed(cfg.dark_on_temp);
		off_t = nxt.profile ? $signed(cfg.sun_off_temp) : $signed(cfg.dark_off_temp);
		// on test first: crossed thresholds turn the heater on
		if (temp < on_t) begin
			nxt.heater = 1'b1;
		end else if (temp > off_t) begin
			nxt.heater = 1'b0;
		end else begin
			nxt.heater = cur.heater;
		end
	end
endmodule

[sv/orbit_aware_heater_thermostat_unit.sv]
// Orbit-aware heater thermostat. Each tick transfer carries the time in seconds, the panel
// power and the heater temperature; each yields exactly one result transfer with the heater
// switch and the active profile (1 sunshine, 0 eclipse) after that tick. A tick is taken
// into an input register; the profile update plus hysteresis run combinationally from there
// into the state and result registers, so the block sustains one tick per clock while results
// are taken; the state update loop (two 32-bit subtracts and compares) is what sets that rate.
// The tick side keeps accepting while a finished result waits, and stalls only when both the
// input and result registers are full. Configuration is written
// through cfg_we/cfg_index/cfg_data with the block idle; registers 0-3 take cfg_data[7:0] as
// signed degrees C, register 4 takes cfg_data[19:0], registers 5-7 take cfg_data[15:0].
// Time differences wrap modulo 2^32.
module orbit_aware_heater_thermostat_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [oaht_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [oaht_pkg::CFG_DATA_W-1:0]     cfg_data,
	oaht_tick_if.sink                           tick,
	oaht_result_if.source                       result
);
	import oaht_pkg::*;

	cfg_t   cfg_q;
	state_t state_q;
	state_t state_nxt;
	tick_t  tick_s1;
	logic   valid_s1;
	logic   out_valid_q;
	logic   advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SUN_ON_TEMP:    cfg_q.sun_on_temp    <= cfg_data[TEMP_W-1:0];
				REG_SUN_OFF_TEMP:   cfg_q.sun_off_temp   <= cfg_data[TEMP_W-1:0];
				REG_DARK_ON_TEMP:   cfg_q.dark_on_temp   <= cfg_data[TEMP_W-1:0];
				REG_DARK_OFF_TEMP:  cfg_q.dark_off_temp  <= cfg_data[TEMP_W-1:0];
				REG_LIGHT_POWER_MW: cfg_q.light_power_mw <= cfg_data[POWER_W-1:0];
				REG_TUMBLE_TIME_S:  cfg_q.tumble_time_s  <= cfg_data[SPAN_W-1:0];
				REG_ORBIT_PERIOD_S: cfg_q.orbit_period_s <= cfg_data[SPAN_W-1:0];
				REG_HEATUP_TIME_S:  cfg_q.heatup_time_s  <= cfg_data[SPAN_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1 moves on whenever the result register is empty or being drained
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	// Input payload register, no reset needed
	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1.now_s          <= tick.now_s;
			tick_s1.panel_power_mw <= tick.panel_power_mw;
			tick_s1.temperature    <= tick.temperature;
		end
	end

	oaht_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.tick (tick_s1),
		.nxt  (state_nxt)
	);

	// State doubles as result payload: it always holds the outcome of the
	// last tick that moved into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RESET;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.heater_drive     = state_q.heater;
	assign result.sunshine_profile = state_q.profile;
endmodule

[sv/oaht_checker.sv]
module oaht_checker (
	input logic clk,
	input logic arst_n,
	input logic tick_valid,
	input logic tick_ready,
	input logic result_valid,
	input logic result_ready,
	input logic heater_drive,
	input logic sunshine_profile
);

	// Stalled result holds its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(heater_drive) && $stable(sunshine_profile))
		else $error("result changed while stalled");

	// Tick side stalls only behind a waiting result
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_ready |-> result_valid)
		else $error("tick stalled with empty result register");

	// Empty result register means the input side is open
	a_open_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> tick_ready)
		else $error("tick not ready with result register empty");

	// A result only appears after a tick transfer has passed through the input register
	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(tick_valid && tick_ready, 2))
		else $error("result without a tick two cycles earlier");

endmodule

bind orbit_aware_heater_thermostat_unit oaht_checker u_oaht_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.tick_valid       (tick.valid),
	.tick_ready       (tick.ready),
	.result_valid     (result.valid),
	.result_ready     (result.ready),
	.heater_drive     (result.heater_drive),
	.sunshine_profile (result.sunshine_profile)
);
